// ----- sv/ttl_pulse_trigger_conditioner_unit_defines.svh -----
// ----------------------------------------------------------------------------
// TTL pulse trigger conditioner - assertion macros
// Shared property wrappers clocked on i_clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef TTL_PULSE_TRIGGER_CONDITIONER_UNIT_DEFINES_SVH
`define TTL_PULSE_TRIGGER_CONDITIONER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define TTLPTC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define TTLPTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/ttlptc_pkg.sv -----
// ----------------------------------------------------------------------------
// ttlptc_pkg
// Widths, codes, types and helpers of the TTL pulse trigger conditioner.
// ----------------------------------------------------------------------------
package ttlptc_pkg;

    localparam int TIME_BITS     = 48;
    localparam int EVT_BITS      = 48;
    localparam int DRAW_BITS     = 32;
    localparam int CFG_BITS      = 20;
    localparam int DEAD_BITS     = 21;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 21;
    localparam int DIV_CNT_BITS  = $clog2(DRAW_BITS);
    localparam int Q_DEPTH       = 2;
    localparam int Q_PTR_BITS    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_BITS    = $clog2(Q_DEPTH + 1);

    localparam logic [CFG_BITS-1:0]  SUSTAIN_RESET = CFG_BITS'(10);
    localparam logic [DEAD_BITS-1:0] DEAD_RESET    = DEAD_BITS'(100);

    typedef logic [TIME_BITS-1:0] t_time;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_TRIGGER_MODE = 3'd0,
        CFG_DEGLITCH     = 3'd1,
        CFG_DELAY_MIN    = 3'd2,
        CFG_DELAY_MAX    = 3'd3,
        CFG_SUSTAIN      = 3'd4,
        CFG_DEAD         = 3'd5,
        CFG_ACTIVE_HIGH  = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_LEVEL_HIGH = 2'd0,
        MODE_LEVEL_LOW  = 2'd1,
        MODE_RISING     = 2'd2,
        MODE_FALLING    = 2'd3
    } t_trig_mode;

    // Clamped configuration as the datapath uses it.
    typedef struct packed {
        t_trig_mode           mode;
        logic [CFG_BITS-1:0]  dg;
        logic [CFG_BITS-1:0]  dmin;
        logic [CFG_BITS-1:0]  sus;
        logic [DEAD_BITS-1:0] dead;
        logic [DEAD_BITS-1:0] range;
        logic                 active_high;
        logic                 settle;
    } t_cfg;

    typedef struct packed {
        t_time                now;
        logic [DRAW_BITS-1:0] draw;
    } t_job;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DIV,
        B_OFS,
        B_T0,
        B_EV0,
        B_EV1
    } t_back_state;

    typedef struct packed {
        logic pop;
        logic div_step;
        logic load_ofs;
        logic load_t0;
        logic emit0;
        logic emit1;
    } t_back_ctl;

    typedef struct packed {
        logic full;
        logic head_valid;
    } t_q_status;

    function automatic logic [EVT_BITS-1:0] to_evt(input t_time t);
        logic [63:0] wide;
        wide = 64'(t);
        return wide[EVT_BITS-1:0];
    endfunction

endpackage

// ----- sv/ttlptc_ifs.sv -----
// ----------------------------------------------------------------------------
// ttlptc channel interfaces
// Valid/ready channels for samples, output events and register writes.
// ----------------------------------------------------------------------------
interface ttlptc_in_if;
    logic                                valid;
    logic                                ready;
    logic                                level;
    logic [ttlptc_pkg::DRAW_BITS-1:0]    rand_draw;

    modport source (output valid, output level, output rand_draw, input ready);
    modport sink   (input valid, input level, input rand_draw, output ready);
endinterface

interface ttlptc_out_if;
    logic                                valid;
    logic                                ready;
    logic [ttlptc_pkg::EVT_BITS-1:0]     event_time;
    logic                                event_level;
    logic                                last;

    modport source (output valid, output event_time, output event_level,
                    output last, input ready);
    modport sink   (input valid, input event_time, input event_level,
                    input last, output ready);
endinterface

interface ttlptc_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [ttlptc_pkg::CFG_IDX_BITS-1:0]   index;
    logic [ttlptc_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/ttlptc_cfg.sv -----
// ----------------------------------------------------------------------------
// ttlptc_cfg
// Register file and clamp stage; publishes the registered clamped set.
// ----------------------------------------------------------------------------
module ttlptc_cfg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ttlptc_cfg_if.sink         i_cfg,
    output ttlptc_pkg::t_cfg   o_cfg,
    output logic               o_wr
);

    logic [1:0]                          r_mode;
    logic [ttlptc_pkg::CFG_BITS-1:0]     r_dg;
    logic [ttlptc_pkg::CFG_BITS-1:0]     r_dmin;
    logic [ttlptc_pkg::CFG_BITS-1:0]     r_dmax;
    logic [ttlptc_pkg::CFG_BITS-1:0]     r_sus;
    logic [ttlptc_pkg::DEAD_BITS-1:0]    r_dead;
    logic                                r_ah;
    ttlptc_pkg::t_cfg                    r_eff;
    ttlptc_pkg::t_cfg                    n_eff;
    logic                                r_settle;

    logic                                wr_en;
    logic                                hit;
    logic [ttlptc_pkg::CFG_BITS-1:0]     dmin_c;
    logic [ttlptc_pkg::CFG_BITS-1:0]     dmax_c;
    logic [ttlptc_pkg::CFG_BITS-1:0]     sus_c;
    logic [ttlptc_pkg::DEAD_BITS-1:0]    floor_c;

    assign i_cfg.ready = 1'b1;
    assign wr_en       = i_cfg.valid && i_cfg.ready;

    always_comb begin
        case (ttlptc_pkg::t_cfg_idx'(i_cfg.index))
            ttlptc_pkg::CFG_TRIGGER_MODE,
            ttlptc_pkg::CFG_DEGLITCH,
            ttlptc_pkg::CFG_DELAY_MIN,
            ttlptc_pkg::CFG_DELAY_MAX,
            ttlptc_pkg::CFG_SUSTAIN,
            ttlptc_pkg::CFG_DEAD,
            ttlptc_pkg::CFG_ACTIVE_HIGH: hit = 1'b1;
            default:                     hit = 1'b0;
        endcase
    end

    assign o_wr = wr_en && hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 2'd0;
            r_dg     <= '0;
            r_dmin   <= '0;
            r_dmax   <= '0;
            r_sus    <= ttlptc_pkg::SUSTAIN_RESET;
            r_dead   <= ttlptc_pkg::DEAD_RESET;
            r_ah     <= 1'b1;
            r_settle <= 1'b1;
        end else begin
            r_settle <= wr_en;
            if (wr_en) begin
                case (ttlptc_pkg::t_cfg_idx'(i_cfg.index))
                    ttlptc_pkg::CFG_TRIGGER_MODE: r_mode <= i_cfg.data[1:0];
                    ttlptc_pkg::CFG_DEGLITCH:
                        r_dg <= i_cfg.data[ttlptc_pkg::CFG_BITS-1:0];
                    ttlptc_pkg::CFG_DELAY_MIN:
                        r_dmin <= i_cfg.data[ttlptc_pkg::CFG_BITS-1:0];
                    ttlptc_pkg::CFG_DELAY_MAX:
                        r_dmax <= i_cfg.data[ttlptc_pkg::CFG_BITS-1:0];
                    ttlptc_pkg::CFG_SUSTAIN:
                        r_sus <= i_cfg.data[ttlptc_pkg::CFG_BITS-1:0];
                    ttlptc_pkg::CFG_DEAD:
                        r_dead <= i_cfg.data[ttlptc_pkg::DEAD_BITS-1:0];
                    ttlptc_pkg::CFG_ACTIVE_HIGH:  r_ah <= i_cfg.data[0];
                    default: ;
                endcase
            end
        end
    end

    // Clamp chain: min >= deglitch, max >= min, sustain >= 1, dead >= max + sustain.
    always_comb begin
        dmin_c  = (r_dmin < r_dg) ? r_dg : r_dmin;
        dmax_c  = (r_dmax < dmin_c) ? dmin_c : r_dmax;
        sus_c   = (r_sus == '0) ? ttlptc_pkg::CFG_BITS'(1) : r_sus;
        floor_c = ttlptc_pkg::DEAD_BITS'(dmax_c) + ttlptc_pkg::DEAD_BITS'(sus_c);

        n_eff             = r_eff;
        n_eff.mode        = ttlptc_pkg::t_trig_mode'(r_mode);
        n_eff.dg          = r_dg;
        n_eff.dmin        = dmin_c;
        n_eff.sus         = sus_c;
        n_eff.dead        = (r_dead < floor_c) ? floor_c : r_dead;
        n_eff.range       = ttlptc_pkg::DEAD_BITS'(dmax_c) - ttlptc_pkg::DEAD_BITS'(dmin_c)
                            + ttlptc_pkg::DEAD_BITS'(1);
        n_eff.active_high = r_ah;
        n_eff.settle      = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        r_eff <= n_eff;
    end

    always_comb begin
        o_cfg        = r_eff;
        o_cfg.settle = r_settle;
    end

endmodule

// ----- sv/ttlptc_front.sv -----
// ----------------------------------------------------------------------------
// ttlptc_front
// Sample timebase, edge and deglitch tracking, dead time and trigger decision.
// ----------------------------------------------------------------------------
module ttlptc_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ttlptc_in_if.sink             i_in,
    input  ttlptc_pkg::t_cfg      i_cfg,
    input  logic                  i_cfg_wr,
    input  ttlptc_pkg::t_q_status i_q,
    output logic                  o_push,
    output ttlptc_pkg::t_job      o_job
);

    ttlptc_pkg::t_time r_clock, n_clock;
    ttlptc_pkg::t_time r_stable, n_stable;
    ttlptc_pkg::t_time r_ready_t, n_ready_t;
    logic              r_prev, n_prev;

    logic accept, rising, falling, stable, armed, cond, fire;

    function automatic ttlptc_pkg::t_time sat_add(input ttlptc_pkg::t_time a,
                                                  input logic [ttlptc_pkg::DEAD_BITS-1:0] b);
        logic [ttlptc_pkg::TIME_BITS:0] s;
        s = {1'b0, a} + (ttlptc_pkg::TIME_BITS + 1)'(b);
        return s[ttlptc_pkg::TIME_BITS] ? '1 : s[ttlptc_pkg::TIME_BITS-1:0];
    endfunction

    assign i_in.ready = !i_q.full && !i_cfg.settle;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        rising  = i_in.level && !r_prev;
        falling = !i_in.level && r_prev;
        stable  = r_clock >= r_stable;
        armed   = r_clock >= r_ready_t;
        case (i_cfg.mode)
            ttlptc_pkg::MODE_LEVEL_HIGH: cond = i_in.level;
            ttlptc_pkg::MODE_LEVEL_LOW:  cond = !i_in.level;
            ttlptc_pkg::MODE_RISING:     cond = rising;
            ttlptc_pkg::MODE_FALLING:    cond = falling;
            default:                     cond = falling;
        endcase
        fire = stable && armed && cond;
    end

    always_comb begin
        n_clock   = r_clock;
        n_prev    = r_prev;
        n_stable  = r_stable;
        n_ready_t = r_ready_t;
        if (accept) begin
            n_clock = r_clock + ttlptc_pkg::TIME_BITS'(1);
            n_prev  = i_in.level;
            if (rising || falling) begin
                n_stable = sat_add(r_clock, ttlptc_pkg::DEAD_BITS'(i_cfg.dg));
            end
            if (fire) begin
                n_ready_t = sat_add(r_clock, i_cfg.dead);
            end
            // Timebase wraps: every window has passed.
            if (r_clock == '1) begin
                n_stable  = '0;
                n_ready_t = '0;
            end
        end
        if (i_cfg_wr) begin
            n_stable  = '0;
            n_ready_t = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock   <= '0;
            r_prev    <= 1'b0;
            r_stable  <= '0;
            r_ready_t <= '0;
        end else begin
            r_clock   <= n_clock;
            r_prev    <= n_prev;
            r_stable  <= n_stable;
            r_ready_t <= n_ready_t;
        end
    end

    assign o_push   = accept && fire;
    assign o_job.now  = r_clock;
    assign o_job.draw = i_in.rand_draw;

endmodule

// ----- sv/ttlptc_fifo.sv -----
// ----------------------------------------------------------------------------
// ttlptc_fifo
// Short register queue of trigger jobs between front and back.
// ----------------------------------------------------------------------------
module ttlptc_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  ttlptc_pkg::t_job      i_job,
    input  logic                  i_pop,
    output ttlptc_pkg::t_job      o_head,
    output ttlptc_pkg::t_q_status o_status
);

    ttlptc_pkg::t_job                     r_mem [ttlptc_pkg::Q_DEPTH];
    logic [ttlptc_pkg::Q_PTR_BITS-1:0]    r_wr_ptr, r_rd_ptr;
    logic [ttlptc_pkg::Q_CNT_BITS-1:0]    r_count;

    logic do_push, do_pop;

    function automatic logic [ttlptc_pkg::Q_PTR_BITS-1:0] ptr_inc(
        input logic [ttlptc_pkg::Q_PTR_BITS-1:0] p);
        return (p == ttlptc_pkg::Q_PTR_BITS'(ttlptc_pkg::Q_DEPTH - 1)) ?
               '0 : p + ttlptc_pkg::Q_PTR_BITS'(1);
    endfunction

    assign o_status.full       = r_count == ttlptc_pkg::Q_CNT_BITS'(ttlptc_pkg::Q_DEPTH);
    assign o_status.head_valid = r_count != '0;
    assign do_push             = i_push && !o_status.full;
    assign do_pop              = i_pop && o_status.head_valid;
    assign o_head              = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + ttlptc_pkg::Q_CNT_BITS'(1);
                2'b01:   r_count <= r_count - ttlptc_pkg::Q_CNT_BITS'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- sv/ttlptc_back.sv -----
// ----------------------------------------------------------------------------
// ttlptc_back
// Delay draw by restoring remainder, event time sums and output register.
// ----------------------------------------------------------------------------
module ttlptc_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ttlptc_pkg::t_cfg      i_cfg,
    input  ttlptc_pkg::t_job      i_head,
    input  logic                  i_head_valid,
    output logic                  o_pop,
    ttlptc_out_if.source          o_out
);

    ttlptc_pkg::t_back_state                 r_state, n_state;
    ttlptc_pkg::t_back_ctl                   ctl;
    logic [ttlptc_pkg::DIV_CNT_BITS-1:0]     r_cnt;
    logic [ttlptc_pkg::DRAW_BITS-1:0]        r_dividend;
    logic [ttlptc_pkg::CFG_BITS-1:0]         r_rem;
    logic [ttlptc_pkg::DEAD_BITS-1:0]        r_delay;
    ttlptc_pkg::t_time                       r_now;
    ttlptc_pkg::t_time                       r_acc;

    logic                                    r_out_valid;
    logic [ttlptc_pkg::EVT_BITS-1:0]         r_out_time;
    logic                                    r_out_level;
    logic                                    r_out_last;

    logic                                    out_free;
    logic [ttlptc_pkg::DEAD_BITS-1:0]        trial;
    logic [ttlptc_pkg::CFG_BITS-1:0]         rem_next;

    assign out_free = !r_out_valid || o_out.ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ttlptc_pkg::B_IDLE: if (i_head_valid) n_state = ttlptc_pkg::B_DIV;
            ttlptc_pkg::B_DIV:  if (r_cnt == '0) n_state = ttlptc_pkg::B_OFS;
            ttlptc_pkg::B_OFS:  n_state = ttlptc_pkg::B_T0;
            ttlptc_pkg::B_T0:   n_state = ttlptc_pkg::B_EV0;
            ttlptc_pkg::B_EV0:  if (out_free) n_state = ttlptc_pkg::B_EV1;
            ttlptc_pkg::B_EV1:  if (out_free) n_state = ttlptc_pkg::B_IDLE;
            default:            n_state = ttlptc_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        ctl = '0;
        case (r_state)
            ttlptc_pkg::B_IDLE: ctl.pop      = i_head_valid;
            ttlptc_pkg::B_DIV:  ctl.div_step = 1'b1;
            ttlptc_pkg::B_OFS:  ctl.load_ofs = 1'b1;
            ttlptc_pkg::B_T0:   ctl.load_t0  = 1'b1;
            ttlptc_pkg::B_EV0:  ctl.emit0    = out_free;
            ttlptc_pkg::B_EV1:  ctl.emit1    = out_free;
            default:            ctl          = '0;
        endcase
    end

    assign o_pop = ctl.pop;

    // One quotient bit per cycle; the remainder stays below the range.
    always_comb begin
        trial = {r_rem, r_dividend[ttlptc_pkg::DRAW_BITS-1]};
        if (trial >= i_cfg.range) begin
            rem_next = ttlptc_pkg::CFG_BITS'(trial - i_cfg.range);
        end else begin
            rem_next = trial[ttlptc_pkg::CFG_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ttlptc_pkg::B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.pop) begin
            r_dividend <= i_head.draw;
            r_now      <= i_head.now;
            r_rem      <= '0;
            r_cnt      <= ttlptc_pkg::DIV_CNT_BITS'(ttlptc_pkg::DRAW_BITS - 1);
        end
        if (ctl.div_step) begin
            r_rem      <= rem_next;
            r_dividend <= {r_dividend[ttlptc_pkg::DRAW_BITS-2:0], 1'b0};
            r_cnt      <= r_cnt - ttlptc_pkg::DIV_CNT_BITS'(1);
        end
        if (ctl.load_ofs) begin
            r_delay <= ttlptc_pkg::DEAD_BITS'(i_cfg.dmin) + ttlptc_pkg::DEAD_BITS'(r_rem);
        end
        if (ctl.load_t0) begin
            r_acc <= r_now + ttlptc_pkg::TIME_BITS'(r_delay);
        end
        if (ctl.emit0) begin
            r_acc <= r_acc + ttlptc_pkg::TIME_BITS'(i_cfg.sus);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.emit0 || ctl.emit1) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.emit0 || ctl.emit1) begin
            r_out_time  <= ttlptc_pkg::to_evt(r_acc);
            r_out_level <= i_cfg.active_high ^ ctl.emit1;
            r_out_last  <= ctl.emit1;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.event_time  = r_out_time;
    assign o_out.event_level = r_out_level;
    assign o_out.last        = r_out_last;

endmodule

// ----- sv/ttl_pulse_trigger_conditioner_unit.sv -----
// ----------------------------------------------------------------------------
// ttl_pulse_trigger_conditioner_unit
// Deglitched TTL trigger with random pulse delay, sustain and dead time.
// ----------------------------------------------------------------------------
//
//  channel  | dir | fields                               | transaction
//  ---------+-----+--------------------------------------+------------------------
//  i_in     | in  | level, rand_draw[31:0]               | one sample tick
//  o_out    | out | event_time[47:0], event_level, last  | one timed output event
//  i_cfg    | in  | index[2:0], data[20:0]               | one register write
//
//  A sample that does not fire is handled in the front stage alone. A firing
//  sample adds a job for the back stage, which takes one job at a time: it
//  pops the job, forms the bit-serial remainder of the draw, then the delay
//  and start-time sums, then emits the event pair, stalling while o_out is busy.
//  The two-entry job queue lets the front keep sampling while the back works;
//  i_in.ready drops when the queue is full and for one cycle after a register
//  write while the clamped set reloads. Reset is synchronous, active low.
//  o_out holds its transaction while ready is low; only the back stalls.
//
// ----------------------------------------------------------------------------
`include "ttl_pulse_trigger_conditioner_unit_defines.svh"

module ttl_pulse_trigger_conditioner_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ttlptc_in_if.sink     i_in,
    ttlptc_out_if.source  o_out,
    ttlptc_cfg_if.sink    i_cfg
);

    // Clamped configuration and the write strobe that clears the windows.
    ttlptc_pkg::t_cfg      cfg;
    logic                  cfg_wr;

    // Job queue between trigger decision and pulse scheduling.
    ttlptc_pkg::t_job      push_job;
    ttlptc_pkg::t_job      head_job;
    ttlptc_pkg::t_q_status q_status;
    logic                  push;
    logic                  pop;

    ttlptc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg),
        .o_wr    (cfg_wr)
    );

    // Front: timebase, edge tracking, deglitch and dead time, fire decision.
    ttlptc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (cfg),
        .i_cfg_wr (cfg_wr),
        .i_q      (q_status),
        .o_push   (push),
        .o_job    (push_job)
    );

    ttlptc_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_head   (head_job),
        .o_status (q_status)
    );

    // Back: draw remainder, event times, output register.
    ttlptc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_head       (head_job),
        .i_head_valid (q_status.head_valid),
        .o_pop        (pop),
        .o_out        (o_out)
    );

    // A full queue must hold off new samples, or a trigger would be dropped.
    `TTLPTC_ASSERT_NOW(a_full_blocks_input, q_status.full, !i_in.ready, "sample taken with full queue")
    // The clamped set reloads after a write; no sample may use the old one.
    `TTLPTC_ASSERT_NEXT(a_settle_after_write, cfg_wr, !i_in.ready, "sample taken while config settles")
    // The pulse end always returns the output to its idle level.
    `TTLPTC_ASSERT_NOW(a_end_level, o_out.valid && o_out.last, o_out.event_level == !cfg.active_high, "pulse end level wrong")
    // The back never pops an empty queue.
    `TTLPTC_ASSERT_NOW(a_pop_nonempty, pop, q_status.head_valid, "pop from empty queue")

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - TTL pulse trigger conditioner testbench
// Sends sample ticks and register writes over the valid/ready channels,
// mirrors the deglitch, dead-time and trigger logic tick by tick, and checks
// every pulse start and end event in order against the mirrored values.
// ----------------------------------------------------------------------------
module tb;
    import ttlptc_pkg::*;

    // generous bound: every tick firing, slow receiver and the long hold
    localparam int unsigned LIMIT_CYCLES  = 1_000_000;
    // back stage works one job at a time; two jobs may sit in the queue
    localparam int          SETTLE_CYCLES = 120;
    localparam int          HOLD_CYCLES   = 400;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_IDX = 3'd7;
    localparam longint unsigned TIME_MASK = (64'd1 << TIME_BITS) - 64'd1;

    typedef struct {
        logic [EVT_BITS-1:0] at;
        logic                lvl;
        logic                is_end;
    } t_pulse_edge;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ttlptc_in_if  smp_if ();
    ttlptc_out_if evt_if ();
    ttlptc_cfg_if reg_if ();

    ttl_pulse_trigger_conditioner_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (smp_if),
        .o_out   (evt_if),
        .i_cfg   (reg_if)
    );

    // Mirror of the raw registers; clamps are applied per tick, as in the block.
    t_trig_mode           mode_q;
    logic [CFG_BITS-1:0]  deglitch_q;
    logic [CFG_BITS-1:0]  dly_min_q;
    logic [CFG_BITS-1:0]  dly_max_q;
    logic [CFG_BITS-1:0]  sustain_q;
    logic [DEAD_BITS-1:0] dead_q;
    logic                 active_high_q;

    // Mirror of the tick state.
    t_time tick_q;
    t_time settle_at;
    t_time rearm_at;
    logic  prev_lvl;

    t_pulse_edge pulse_edges[$];

    int          src_idle_pct   = 0;
    int          sink_stall_pct = 0;
    int          hold_reqs      = 0;
    int          hold_seen      = 0;
    int          hold_left      = 0;
    int          mismatches     = 0;
    int unsigned cycles         = 0;

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Deadlines saturate at the largest time value instead of wrapping.
    function automatic t_time sat_deadline(input longint unsigned base,
                                           input longint unsigned span);
        longint unsigned sum;
        sum = base + span;
        if (sum < base || sum > TIME_MASK)
            return t_time'(TIME_MASK);
        return t_time'(sum);
    endfunction

    // Any real register write restarts both windows; an unused index is dropped.
    function automatic void mirror_reg_write(input logic [CFG_IDX_BITS-1:0]  idx,
                                             input logic [CFG_DATA_BITS-1:0] val);
        case (idx)
            CFG_TRIGGER_MODE: mode_q        = t_trig_mode'(val[1:0]);
            CFG_DEGLITCH:     deglitch_q    = val[CFG_BITS-1:0];
            CFG_DELAY_MIN:    dly_min_q     = val[CFG_BITS-1:0];
            CFG_DELAY_MAX:    dly_max_q     = val[CFG_BITS-1:0];
            CFG_SUSTAIN:      sustain_q     = val[CFG_BITS-1:0];
            CFG_DEAD:         dead_q        = val[DEAD_BITS-1:0];
            CFG_ACTIVE_HIGH:  active_high_q = val[0];
            default:          return;
        endcase
        settle_at = '0;
        rearm_at  = '0;
    endfunction

    // Advance one sample tick; queue the pulse pair if the trigger fires.
    function automatic void predict_tick(input logic lvl,
                                         input logic [DRAW_BITS-1:0] draw);
        longint unsigned now, dg, dmin, dmax, sus, dead, delay, t0, t1;
        logic            rise, fall, settled, armed, fire;

        now  = 64'(tick_q);
        dg   = 64'(deglitch_q);
        dmin = (64'(dly_min_q) < dg) ? dg : 64'(dly_min_q);
        dmax = (64'(dly_max_q) < dmin) ? dmin : 64'(dly_max_q);
        sus  = (sustain_q == '0) ? 64'd1 : 64'(sustain_q);
        dead = (64'(dead_q) < dmax + sus) ? dmax + sus : 64'(dead_q);

        rise    = lvl & ~prev_lvl;
        fall    = ~lvl & prev_lvl;
        settled = now >= 64'(settle_at);
        armed   = now >= 64'(rearm_at);

        // an edge restarts the deglitch window, judged on the old window
        if (rise | fall)
            settle_at = sat_deadline(now, dg);

        case (mode_q)
            MODE_LEVEL_HIGH: fire = lvl;
            MODE_LEVEL_LOW:  fire = ~lvl;
            MODE_RISING:     fire = rise;
            default:         fire = fall;
        endcase
        fire = fire & settled & armed;

        if (fire) begin
            delay    = dmin + 64'(draw) % (64'd1 + dmax - dmin);
            t0       = (now + delay) & TIME_MASK;
            t1       = (t0 + sus) & TIME_MASK;
            rearm_at = sat_deadline(now, dead);
            pulse_edges.push_back('{at: t0[EVT_BITS-1:0], lvl: active_high_q,
                                    is_end: 1'b0});
            pulse_edges.push_back('{at: t1[EVT_BITS-1:0], lvl: ~active_high_q,
                                    is_end: 1'b1});
        end

        prev_lvl = lvl;
        tick_q   = tick_q + t_time'(1);
        // a wrapped clock leaves every window behind
        if (tick_q == '0) begin
            settle_at = '0;
            rearm_at  = '0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------------

    // Offer one sample; keep valid high afterwards so back-to-back ticks
    // never drop it. Idle gaps drop valid before the next offer.
    task automatic send_sample(input logic lvl, input logic [DRAW_BITS-1:0] draw);
        while ($urandom_range(99) < src_idle_pct) begin
            smp_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        smp_if.valid     <= 1'b1;
        smp_if.level     <= lvl;
        smp_if.rand_draw <= draw;
        @(posedge i_clk);
        while (!smp_if.ready) @(posedge i_clk);
        predict_tick(lvl, draw);
    endtask

    // Hold valid high across a batch; the caller drops it after the last write.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0]  idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        reg_if.valid <= 1'b1;
        reg_if.index <= idx;
        reg_if.data  <= val;
        @(posedge i_clk);
        while (!reg_if.ready) @(posedge i_clk);
        mirror_reg_write(idx, val);
    endtask

    // Drain all pending events, then give the back stage time to finish its pop.
    task automatic wait_idle();
        smp_if.valid <= 1'b0;
        while (pulse_edges.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input t_trig_mode  mode,
                             input int unsigned dg, dmin, dmax, sus, dead,
                             input logic        ah);
        wait_idle();
        write_reg(CFG_TRIGGER_MODE, CFG_DATA_BITS'(mode));
        write_reg(CFG_DEGLITCH,     CFG_DATA_BITS'(dg));
        write_reg(CFG_DELAY_MIN,    CFG_DATA_BITS'(dmin));
        write_reg(CFG_DELAY_MAX,    CFG_DATA_BITS'(dmax));
        write_reg(CFG_SUSTAIN,      CFG_DATA_BITS'(sus));
        write_reg(CFG_DEAD,         CFG_DATA_BITS'(dead));
        write_reg(CFG_ACTIVE_HIGH,  CFG_DATA_BITS'(ah));
        reg_if.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls plus a long hold on request
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen     <= hold_reqs;
            hold_left     <= HOLD_CYCLES;
            evt_if.ready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            evt_if.ready  <= 1'b0;
        end else begin
            evt_if.ready  <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Compare each event transaction with the oldest pending expectation.
    always @(posedge i_clk) begin : check_events
        t_pulse_edge want;
        if (i_rst_n && evt_if.valid && evt_if.ready) begin
            if (pulse_edges.size() == 0) begin
                $error("unexpected event: event_time %0d event_level %0b last %0b",
                       evt_if.event_time, evt_if.event_level, evt_if.last);
                mismatches++;
            end else begin
                want = pulse_edges.pop_front();
                if (evt_if.event_time !== want.at) begin
                    $error("event_time: expected %0d, got %0d", want.at,
                           evt_if.event_time);
                    mismatches++;
                end
                if (evt_if.event_level !== want.lvl) begin
                    $error("event_level: expected %0b, got %0b", want.lvl,
                           evt_if.event_level);
                    mismatches++;
                end
                if (evt_if.last !== want.is_end) begin
                    $error("last: expected %0b, got %0b", want.is_end, evt_if.last);
                    mismatches++;
                end
            end
        end
    end

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("ttl_pulse_trigger_conditioner_unit: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset registers: level high, no delay, sustain 10, dead time 100.
    task automatic test_reset_values();
        send_sample(1'b0, 32'h0000_0000);
        send_sample(1'b1, 32'hFFFF_FFFF);
        send_sample(1'b1, 32'h0000_0000);   // locked out by the dead time
        send_sample(1'b0, 32'hFFFF_FFFF);
    endtask

    // Walk every trigger condition; each short sequence fires once.
    task automatic test_trigger_modes();
        for (int m = 0; m < 4; m++) begin
            configure(t_trig_mode'(m), 0, 2, 5, 1, 0, m[0]);
            send_sample(1'b1, 32'h0000_0000);
            send_sample(1'b0, 32'hFFFF_FFFF);
            send_sample(1'b1, $urandom);
        end
    endtask

    // All registers at full scale, then a set where every clamp takes hold.
    task automatic test_register_extremes();
        configure(MODE_LEVEL_HIGH, 32'hFFFFF, 32'hFFFFF, 32'hFFFFF, 32'hFFFFF,
                  32'h1FFFFF, 1'b1);
        send_sample(1'b1, 32'hFFFF_FFFF);
        send_sample(1'b0, 32'h0000_0000);
        // min below deglitch, max below min, zero sustain, zero dead time
        configure(MODE_FALLING, 7, 3, 0, 0, 0, 1'b0);
        send_sample(1'b1, $urandom);
        send_sample(1'b0, $urandom);
        send_sample(1'b1, $urandom);
        send_sample(1'b0, $urandom);        // glitch inside deglitch and dead time
    endtask

    // A write to the unused index must not restart the dead time.
    task automatic test_unused_index();
        configure(MODE_LEVEL_HIGH, 0, 0, 0, 1, 50, 1'b1);
        send_sample(1'b1, $urandom);
        wait_idle();
        write_reg(CFG_UNUSED_IDX, 21'h1FFFFF);
        reg_if.valid <= 1'b0;
        send_sample(1'b1, $urandom);        // still locked out
        wait_idle();
        write_reg(CFG_ACTIVE_HIGH, 21'h0);
        reg_if.valid <= 1'b0;
        send_sample(1'b1, $urandom);        // real write re-arms at once
    endtask

    // Hold the receiver for a long stretch while samples keep coming, so the
    // job queue fills and the sample channel stalls.
    task automatic test_backpressure();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        configure(MODE_LEVEL_HIGH, 0, 0, 3, 1, 0, 1'b1);
        hold_reqs++;
        for (int k = 0; k < 40; k++)
            send_sample(1'b1, $urandom);
    endtask

    // Level runs of random length, mostly long enough to pass deglitch,
    // with one-tick glitches mixed in.
    task automatic run_level_runs(input int n_items);
        int   run_left;
        logic lvl;
        lvl      = 1'($urandom_range(1));
        run_left = 0;
        for (int k = 0; k < n_items; k++) begin
            if (run_left == 0) begin
                lvl      = ~lvl;
                run_left = ($urandom_range(99) < 20) ? 1 : $urandom_range(2, 14);
            end
            run_left--;
            send_sample(lvl, $urandom);
        end
    endtask

    // Several random register sets plus the all-zero set, where the clamps
    // leave a dead time of one tick.
    task automatic test_random_traffic(input int idle_src, input int stall_sink);
        src_idle_pct   = idle_src;
        sink_stall_pct = stall_sink;
        for (int s = 0; s < 5; s++) begin
            if (s == 4)
                configure(t_trig_mode'($urandom_range(3)), 0, 0, 0, 0, 0,
                          1'($urandom_range(1)));
            else
                configure(t_trig_mode'($urandom_range(3)), $urandom_range(6),
                          $urandom_range(8), $urandom_range(16), $urandom_range(6),
                          $urandom_range(40), 1'($urandom_range(1)));
            run_level_runs(110);
        end
    endtask

    initial begin
        // drive every input known from time zero
        i_rst_n          <= 1'b0;
        smp_if.valid     <= 1'b0;
        smp_if.level     <= 1'b0;
        smp_if.rand_draw <= '0;
        reg_if.valid     <= 1'b0;
        reg_if.index     <= CFG_TRIGGER_MODE;
        reg_if.data      <= '0;

        // mirror the reset state
        mode_q        = MODE_LEVEL_HIGH;
        deglitch_q    = '0;
        dly_min_q     = '0;
        dly_max_q     = '0;
        sustain_q     = SUSTAIN_RESET;
        dead_q        = DEAD_RESET;
        active_high_q = 1'b1;
        tick_q        = '0;
        settle_at     = '0;
        rearm_at      = '0;
        prev_lvl      = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_trigger_modes();
        test_register_extremes();
        test_unused_index();
        test_backpressure();
        test_random_traffic(6, 57);
        test_random_traffic(57, 6);
        test_random_traffic(0, 0);

        // drain, then give late or stray events time to show up
        wait_idle();

        if (mismatches == 0)
            $display("ttl_pulse_trigger_conditioner_unit: match");
        else
            $display("ttl_pulse_trigger_conditioner_unit: mismatch");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/ttlptc_pkg.sv
sv/ttlptc_ifs.sv
sv/ttlptc_cfg.sv
sv/ttlptc_front.sv
sv/ttlptc_fifo.sv
sv/ttlptc_back.sv
sv/ttl_pulse_trigger_conditioner_unit.sv
verif/tb.sv
